/* rtl/core/cla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types and constants of the command line assembler.
// ----------------------------------------------------------------------------
package cla_pkg;

    localparam int LineMax = 1024;
    localparam int AddrW   = $clog2(LineMax);
    localparam int LenW    = AddrW + 1;

    // input opcodes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_EOF  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // result status codes
    localparam logic [1:0] ST_WAIT  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_DATA  = 2'd3;

    // command kinds after classification
    localparam logic [2:0] K_CHAR = 3'd0;
    localparam logic [2:0] K_NL   = 3'd1;
    localparam logic [2:0] K_EOF  = 3'd2;
    localparam logic [2:0] K_READ = 3'd3;
    localparam logic [2:0] K_NOP  = 3'd4;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_BS = 8'h5C;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       char_byte;
        logic [AddrW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic        overflowed;
        logic [7:0]  read_data;
        logic [31:0] first_line_number;
        logic [10:0] line_length;
        logic [1:0]  status;
    } t_res;

endpackage

/* rtl/core/command_line_assembler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_assembler_top
// Builds logical command lines from a byte stream; one result per transaction.
// ----------------------------------------------------------------------------
// A user's view: each input transaction (push byte, end of input, read stored
// byte) yields exactly one result transaction. The front classifies bytes and
// holds up to two commands in a queue, so input keeps flowing while the back
// end works or the result side stalls. In the back end, a plain push, end of
// input or the unused opcode is answered straight from idle, and a read goes
// through a registered line-store read first. A newline trims trailing
// spaces and then scans trailing backslashes; the back end walks the
// 1024-byte line store one byte per cycle through its single registered read
// port. The line store is not cleared at reset; only bytes below the current
// length are ever returned.
// ----------------------------------------------------------------------------
module command_line_assembler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: high_bytes_as_space
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] byte_value, [17:8] read_index, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [10:0] line_length, [42:11] first_line_number,
                                        // [50:43] read_data, [51] overflowed, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic          w_cmd_valid;
    logic          w_cmd_pop;
    cla_pkg::t_cmd w_cmd;
    cla_pkg::t_res w_res;

    cla_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_byte      (s_axis_tdata[7:0]),
        .i_idx       (s_axis_tdata[17:8]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    // back end: line store, newline walk-back and the result register
    cla_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_res)
    );

    assign m_axis_tuser = w_res.status;
    assign m_axis_tdata = {4'd0, w_res.overflowed, w_res.read_data,
                           w_res.first_line_number, w_res.line_length};

    // stored length never passes the buffer size
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_res.line_length <= 11'(cla_pkg::LineMax)))
        else $error("line length beyond buffer size");

    // data byte only on read results
    a_data_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_res.status != cla_pkg::ST_DATA) |-> (w_res.read_data == 8'd0))
        else $error("read data on a non-read result");

    // end of input is reported only for an empty line
    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_res.status == cla_pkg::ST_END) |-> (w_res.line_length == 11'd0))
        else $error("end of input with a non-empty line");

endmodule

/* rtl/core/cla_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_front
// Accepts input transactions, classifies them and queues commands.
// ----------------------------------------------------------------------------
module cla_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_byte,
    input  logic [cla_pkg::AddrW-1:0] i_idx,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop,
    output cla_pkg::t_cmd o_cmd
);

    logic          r_high_sp;
    cla_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    cla_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd.char_byte = i_byte;
        w_cmd.idx       = i_idx;
        case (i_opcode)
            cla_pkg::OP_PUSH: begin
                if (i_byte == cla_pkg::CH_NL) begin
                    w_cmd.kind = cla_pkg::K_NL;
                end else begin
                    w_cmd.kind = cla_pkg::K_CHAR;
                    if (i_byte < cla_pkg::CH_SP || (r_high_sp && i_byte[7])) begin
                        w_cmd.char_byte = cla_pkg::CH_SP;
                    end
                end
            end
            cla_pkg::OP_EOF:  w_cmd.kind = cla_pkg::K_EOF;
            cla_pkg::OP_READ: w_cmd.kind = cla_pkg::K_READ;
            default:          w_cmd.kind = cla_pkg::K_NOP;
        endcase
    end

    assign o_ready     = (r_count != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_sp <= 1'b1;
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_count   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_high_sp <= i_cfg_wdata;
            end
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* rtl/core/cla_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_back
// Executes queued commands against the line store; owns the result register.
// ----------------------------------------------------------------------------
module cla_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    input  cla_pkg::t_cmd i_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cla_pkg::t_res o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_TRIM  = 3'd2;
    localparam logic [2:0] S_COUNT = 3'd3;
    localparam logic [2:0] S_NLEND = 3'd4;

    localparam logic [cla_pkg::LenW-1:0] LenFull = cla_pkg::LenW'(cla_pkg::LineMax);
    localparam logic [cla_pkg::LenW-1:0] LenOne  = cla_pkg::LenW'(1);
    localparam logic [cla_pkg::AddrW-1:0] AddrOne = cla_pkg::AddrW'(1);

    logic [7:0]                 r_mem [cla_pkg::LineMax];
    logic [7:0]                 r_rd_data;

    logic [2:0]                 r_state,  n_state;
    logic [cla_pkg::LenW-1:0]   r_len,    n_len;
    logic                       r_done,   n_done;
    logic [31:0]                r_lb,     n_lb;
    logic [31:0]                r_nl,     n_nl;
    logic                       r_ovf,    n_ovf;
    logic [cla_pkg::AddrW-1:0]  r_pos,    n_pos;
    logic                       r_odd,    n_odd;
    logic                       r_oval,   n_oval;
    cla_pkg::t_res              r_out,    n_out;

    logic                       w_free;
    logic                       w_we;
    logic [cla_pkg::AddrW-1:0]  w_wr_addr;
    logic [cla_pkg::AddrW-1:0]  w_rd_addr;
    logic [cla_pkg::LenW-1:0]   w_len_m1;
    logic [cla_pkg::LenW-1:0]   w_len_m2;
    logic [cla_pkg::LenW-1:0]   e_len;
    logic [31:0]                e_lb;
    logic [31:0]                e_nl;
    logic                       e_ovf;

    assign w_free   = !r_oval || i_out_ready;
    assign w_len_m1 = r_len - LenOne;
    assign w_len_m2 = r_len - (LenOne + LenOne);

    // state after starting a new line, if the previous one completed
    always_comb begin
        e_len = r_done ? '0 : r_len;
        e_lb  = r_done ? r_lb + r_nl : r_lb;
        e_nl  = r_done ? 32'd0 : r_nl;
        e_ovf = r_done ? 1'b0 : r_ovf;
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_done    = r_done;
        n_lb      = r_lb;
        n_nl      = r_nl;
        n_ovf     = r_ovf;
        n_pos     = r_pos;
        n_odd     = r_odd;
        n_oval    = r_oval && !i_out_ready;
        n_out     = r_out;
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_wr_addr = e_len[cla_pkg::AddrW-1:0];
        w_rd_addr = r_pos;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        cla_pkg::K_CHAR, cla_pkg::K_EOF, cla_pkg::K_NOP: begin
                            if (w_free) begin
                                o_cmd_pop = 1'b1;
                                n_oval    = 1'b1;
                                n_out.read_data = 8'd0;
                                if (i_cmd.kind == cla_pkg::K_NOP) begin
                                    n_out.status = cla_pkg::ST_WAIT;
                                    n_out.line_length = r_len;
                                    n_out.first_line_number = r_lb;
                                    n_out.overflowed = r_ovf;
                                end else begin
                                    n_lb   = e_lb;
                                    n_nl   = e_nl;
                                    n_done = 1'b0;
                                    n_len  = e_len;
                                    n_ovf  = e_ovf;
                                    if (i_cmd.kind == cla_pkg::K_CHAR) begin
                                        n_out.status = cla_pkg::ST_WAIT;
                                        if (e_len >= LenFull) begin
                                            n_ovf = 1'b1;
                                        end else begin
                                            w_we  = 1'b1;
                                            n_len = e_len + LenOne;
                                        end
                                    end else if (e_len != '0) begin
                                        n_done = 1'b1;
                                        n_out.status = cla_pkg::ST_READY;
                                    end else begin
                                        n_out.status = cla_pkg::ST_END;
                                    end
                                    n_out.line_length = n_len;
                                    n_out.first_line_number = e_lb;
                                    n_out.overflowed = n_ovf;
                                end
                            end
                        end
                        cla_pkg::K_READ: begin
                            o_cmd_pop = 1'b1;
                            n_pos     = i_cmd.idx;
                            w_rd_addr = i_cmd.idx;
                            n_state   = S_READ;
                        end
                        cla_pkg::K_NL: begin
                            o_cmd_pop = 1'b1;
                            n_lb   = e_lb;
                            n_nl   = e_nl + 32'd1;
                            n_done = 1'b0;
                            n_len  = e_len;
                            n_ovf  = e_ovf;
                            n_odd  = 1'b0;
                            if (e_len == '0) begin
                                n_state = S_NLEND;
                            end else begin
                                w_rd_addr = w_len_m1[cla_pkg::AddrW-1:0];
                                n_state   = S_TRIM;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_free) begin
                    n_oval = 1'b1;
                    n_out.status = cla_pkg::ST_DATA;
                    n_out.line_length = r_len;
                    n_out.first_line_number = r_lb;
                    n_out.overflowed = r_ovf;
                    n_out.read_data = ({1'b0, r_pos} < r_len) ? r_rd_data : 8'd0;
                    n_state = S_IDLE;
                end
            end
            S_TRIM: begin
                // r_rd_data holds the last stored byte
                if (r_rd_data == cla_pkg::CH_SP) begin
                    n_len = w_len_m1;
                    if (r_len == LenOne) begin
                        n_state = S_NLEND;
                    end else begin
                        w_rd_addr = w_len_m2[cla_pkg::AddrW-1:0];
                    end
                end else if (r_rd_data == cla_pkg::CH_BS) begin
                    n_odd = 1'b1;
                    if (r_len == LenOne) begin
                        n_state = S_NLEND;
                    end else begin
                        n_pos     = w_len_m2[cla_pkg::AddrW-1:0];
                        w_rd_addr = w_len_m2[cla_pkg::AddrW-1:0];
                        n_state   = S_COUNT;
                    end
                end else begin
                    n_state = S_NLEND;
                end
            end
            S_COUNT: begin
                if (r_rd_data == cla_pkg::CH_BS) begin
                    n_odd = ~r_odd;
                    if (r_pos == '0) begin
                        n_state = S_NLEND;
                    end else begin
                        n_pos     = r_pos - AddrOne;
                        w_rd_addr = r_pos - AddrOne;
                    end
                end else begin
                    n_state = S_NLEND;
                end
            end
            S_NLEND: begin
                if (w_free) begin
                    n_oval = 1'b1;
                    n_out.read_data = 8'd0;
                    n_out.first_line_number = r_lb;
                    n_out.overflowed = r_ovf;
                    if (r_odd) begin
                        n_len = w_len_m1;
                        n_out.status = cla_pkg::ST_WAIT;
                    end else begin
                        n_done = 1'b1;
                        n_out.status = cla_pkg::ST_READY;
                    end
                    n_out.line_length = n_len;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= i_cmd.char_byte;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_pos <= n_pos;
        r_odd <= n_odd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_done  <= 1'b0;
            r_lb    <= 32'd0;
            r_nl    <= 32'd0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_done  <= n_done;
            r_lb    <= n_lb;
            r_nl    <= n_nl;
            r_ovf   <= n_ovf;
            r_oval  <= n_oval;
        end
    end

    assign o_out_valid = r_oval;
    assign o_out       = r_out;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for command_line_assembler_top.
// ----------------------------------------------------------------------------
// A directed table covers the corner cases first: end of input on an empty
// line, control and high bytes, reads, continuation and completed lines, and
// the unused opcode. A long line then fills the buffer past its end and makes
// the newline walk back over a long run of spaces. Random traffic follows:
// mostly well-formed lines with random content, plus reads, end-of-input
// commands and noise. A local line model predicts every result transaction,
// and each result is checked field by field against the oldest expected one.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    // opcode 3 has no name in the package; the block treats it as a no-op
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SettleTicks = 16;
    localparam int         ShownErrors = 10;

    // one directed stimulus row; want is used only where typed is set
    typedef struct packed {
        logic [1:0]    op;
        logic [7:0]    byte_value;
        logic [9:0]    read_index;
        bit            typed;
        cla_pkg::t_res want;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // [7:0] byte_value, [17:8] read_index, rest zero
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // [10:0] line_length, [42:11] first_line_number,
                                        // [50:43] read_data, [51] overflowed
    logic [1:0]  m_axis_tuser;          // [1:0] status

    command_line_assembler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Line model: own copy of the stored line and counters
    // ------------------------------------------------------------------------
    logic [7:0]  line_mem [cla_pkg::LineMax];
    int          cur_len        = 0;
    bit          line_closed    = 1'b0;
    logic [31:0] lines_before_q = '0;
    logic [31:0] nl_in_line     = '0;
    bit          ovf_q          = 1'b0;
    bit          hi_space       = 1'b1;   // register value after reset
    int          written_hw     = 0;      // entries below this have been written

    cla_pkg::t_res pending_results [$];
    int            mismatch_count = 0;
    int            items_sent     = 0;
    bit            no_idle        = 1'b0;   // both sides run back to back while set
    int            stall_left     = 0;

    function automatic cla_pkg::t_res predict_line_result(logic [1:0] op, logic [7:0] b,
                                                          logic [9:0] idx);
        cla_pkg::t_res r;
        logic [7:0]    c;
        int            run;
        r = '0;
        r.status = cla_pkg::ST_WAIT;
        // a push or end of input after a finished line opens the next one
        if ((op == cla_pkg::OP_PUSH || op == cla_pkg::OP_EOF) && line_closed) begin
            lines_before_q = lines_before_q + nl_in_line;
            cur_len        = 0;
            nl_in_line     = '0;
            line_closed    = 1'b0;
            ovf_q          = 1'b0;
        end
        case (op)
            cla_pkg::OP_PUSH: begin
                if (b == cla_pkg::CH_NL) begin
                    nl_in_line = nl_in_line + 1;
                    while (cur_len > 0 && line_mem[cur_len-1] == cla_pkg::CH_SP)
                        cur_len--;
                    run = 0;
                    while (run < cur_len && line_mem[cur_len-1-run] == cla_pkg::CH_BS)
                        run++;
                    if (run % 2 == 1) begin
                        cur_len--;              // odd run: drop one, line goes on
                    end else begin
                        line_closed = 1'b1;
                        r.status    = cla_pkg::ST_READY;
                    end
                end else begin
                    c = (b < cla_pkg::CH_SP || (hi_space && b[7])) ? cla_pkg::CH_SP : b;
                    if (cur_len >= cla_pkg::LineMax) begin
                        ovf_q = 1'b1;
                    end else begin
                        line_mem[cur_len] = c;
                        cur_len++;
                        if (cur_len > written_hw)
                            written_hw = cur_len;
                    end
                end
            end
            cla_pkg::OP_EOF: begin
                if (cur_len > 0) begin
                    line_closed = 1'b1;
                    r.status    = cla_pkg::ST_READY;
                end else begin
                    r.status = cla_pkg::ST_END;
                end
            end
            cla_pkg::OP_READ: begin
                r.status = cla_pkg::ST_DATA;
                if (idx < cur_len)
                    r.read_data = line_mem[idx];
            end
            default: ;
        endcase
        r.line_length       = cur_len[10:0];
        r.first_line_number = lines_before_q;
        r.overflowed        = ovf_q;
        return r;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_line_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 8'($urandom_range(8'h21, 8'h7E));
        if (r < 75) return cla_pkg::CH_SP;
        if (r < 83) return cla_pkg::CH_BS;
        if (r < 90) return 8'($urandom_range(8'h00, 8'h1F));
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    // only written entries are ever addressed; caller makes sure one exists
    function automatic logic [9:0] pick_read_idx();
        int i;
        if ($urandom_range(0, 3) != 0)
            i = $urandom_range(0, cur_len + 2);
        else
            i = $urandom_range(0, cla_pkg::LineMax - 1);
        if (i >= written_hw)
            i = $urandom_range(0, written_hw - 1);
        return i[9:0];
    endfunction

    function automatic t_dir_row mk_row(logic [1:0] op, logic [7:0] b, logic [9:0] idx,
                                        bit typed, logic [1:0] st, int len,
                                        logic [7:0] data);
        t_dir_row row;
        row.op                     = op;
        row.byte_value             = b;
        row.read_index             = idx;
        row.typed                  = typed;
        row.want                   = '0;
        row.want.status            = st;
        row.want.line_length       = len[10:0];
        row.want.read_data         = data;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one input transaction, then queue its expected result
    // ------------------------------------------------------------------------
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] b,
                            input logic [9:0] idx, input bit typed,
                            input cla_pkg::t_res want);
        int            gap;
        cla_pkg::t_res r;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, idx, b};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = predict_line_result(op, b, idx);
        pending_results.push_back(typed ? want : r);
        items_sent++;
    endtask

    // hold off input until every result is back, then let the block settle
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleTicks) @(posedge i_clk);
    endtask

    task automatic write_high_bytes_cfg(input bit v);
        wait_results_done();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        hi_space = v;
    endtask

    // fills the buffer past its end, then a newline trims a long space run and
    // finds an odd backslash run at the end of the kept text
    task automatic send_long_line();
        logic [7:0] b;
        int         k;
        for (k = 0; k < 697; k++) begin
            b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h21, 8'h7E));
            if (b == cla_pkg::CH_BS || b == cla_pkg::CH_NL)
                b = 8'h41;
            send_cmd(cla_pkg::OP_PUSH, b, 10'($urandom), 1'b0, '0);
        end
        repeat (3) send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_BS, 10'($urandom), 1'b0, '0);
        repeat (334) send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_SP, 10'($urandom), 1'b0, '0);
        send_cmd(cla_pkg::OP_READ, 8'($urandom), 10'd1023, 1'b0, '0);
        send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_NL, 10'($urandom), 1'b0, '0);
        send_cmd(cla_pkg::OP_READ, 8'($urandom), 10'd1023, 1'b0, '0);
        send_cmd(cla_pkg::OP_READ, 8'($urandom), 10'd512, 1'b0, '0);
        repeat (10) send_cmd(cla_pkg::OP_READ, 8'($urandom), 10'($urandom), 1'b0, '0);
        send_cmd(cla_pkg::OP_PUSH, 8'h78, 10'($urandom), 1'b0, '0);
        send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_NL, 10'($urandom), 1'b0, '0);
        send_cmd(cla_pkg::OP_EOF, 8'($urandom), 10'($urandom), 1'b0, '0);
        send_cmd(cla_pkg::OP_EOF, 8'($urandom), 10'($urandom), 1'b0, '0);
    endtask

    task automatic send_random_traffic(input int n_items);
        int         stop_at;
        int         kind;
        int         n;
        int         k;
        logic [1:0] op;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // well-formed line: body, optional trailing spaces and
                // backslashes, then newline or end of input
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(0, 12);
                for (k = 0; k < n; k++) begin
                    send_cmd(cla_pkg::OP_PUSH, pick_line_byte(), 10'($urandom), 1'b0, '0);
                    if (written_hw > 0 && $urandom_range(0, 9) == 0)
                        send_cmd(cla_pkg::OP_READ, 8'($urandom), pick_read_idx(),
                                 1'b0, '0);
                end
                repeat ($urandom_range(0, 3))
                    send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_SP, 10'($urandom), 1'b0, '0);
                repeat ($urandom_range(0, 3))
                    send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_BS, 10'($urandom), 1'b0, '0);
                repeat ($urandom_range(0, 2))
                    send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_SP, 10'($urandom), 1'b0, '0);
                if ($urandom_range(0, 9) == 0)
                    send_cmd(cla_pkg::OP_EOF, 8'($urandom), 10'($urandom), 1'b0, '0);
                else
                    send_cmd(cla_pkg::OP_PUSH, cla_pkg::CH_NL, 10'($urandom), 1'b0, '0);
            end else if (kind < 80) begin
                if (written_hw > 0)
                    repeat ($urandom_range(1, 4))
                        send_cmd(cla_pkg::OP_READ, 8'($urandom), pick_read_idx(),
                                 1'b0, '0);
            end else if (kind < 88) begin
                send_cmd(cla_pkg::OP_EOF, 8'($urandom), 10'($urandom), 1'b0, '0);
            end else if (kind < 93) begin
                send_cmd(OP_UNUSED, 8'($urandom), 10'($urandom), 1'b0, '0);
            end else begin
                // noise: any opcode, any byte
                repeat ($urandom_range(1, 8)) begin
                    op = 2'($urandom_range(0, 3));
                    if (op == cla_pkg::OP_READ && written_hw == 0)
                        op = cla_pkg::OP_PUSH;
                    send_cmd(op, 8'($urandom),
                             (op == cla_pkg::OP_READ) ? pick_read_idx() : 10'($urandom),
                             1'b0, '0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls on tready, check each result transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        cla_pkg::t_res got;
        cla_pkg::t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status            = m_axis_tuser;
            got.line_length       = m_axis_tdata[10:0];
            got.first_line_number = m_axis_tdata[42:11];
            got.read_data         = m_axis_tdata[50:43];
            got.overflowed        = m_axis_tdata[51];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= ShownErrors)
                    $display("unexpected result transaction: status %0d len %0d line %0d",
                             got.status, got.line_length, got.first_line_number);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.line_length !== want.line_length ||
                    got.first_line_number !== want.first_line_number ||
                    got.read_data !== want.read_data || got.overflowed !== want.overflowed)
                begin
                    mismatch_count++;
                    if (mismatch_count <= ShownErrors) begin
                        $write("mismatch: exp st %0d len %0d line %0d data %h ovf %0d, ",
                               want.status, want.line_length, want.first_line_number,
                               want.read_data, want.overflowed);
                        $display("got st %0d len %0d line %0d data %h ovf %0d",
                                 got.status, got.line_length, got.first_line_number,
                                 got.read_data, got.overflowed);
                    end
                end
            end
        end
        if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    t_dir_row dir_rows [25];

    initial begin
        // default register value; line starts empty
        dir_rows[0]  = mk_row(cla_pkg::OP_EOF,  8'h00, 10'd0, 1'b1, cla_pkg::ST_END,  0, 8'h00);
        dir_rows[1]  = mk_row(cla_pkg::OP_PUSH, 8'h61, 10'd0, 1'b1, cla_pkg::ST_WAIT, 1, 8'h00);
        dir_rows[2]  = mk_row(cla_pkg::OP_PUSH, 8'h00, 10'd0, 1'b1, cla_pkg::ST_WAIT, 2, 8'h00);
        dir_rows[3]  = mk_row(cla_pkg::OP_PUSH, 8'hFF, 10'd0, 1'b1, cla_pkg::ST_WAIT, 3, 8'h00);
        dir_rows[4]  = mk_row(cla_pkg::OP_PUSH, 8'h7F, 10'd0, 1'b1, cla_pkg::ST_WAIT, 4, 8'h00);
        dir_rows[5]  = mk_row(cla_pkg::OP_PUSH, 8'h1F, 10'd0, 1'b1, cla_pkg::ST_WAIT, 5, 8'h00);
        dir_rows[6]  = mk_row(cla_pkg::OP_READ, 8'h00, 10'd0, 1'b1, cla_pkg::ST_DATA, 5, 8'h61);
        dir_rows[7]  = mk_row(cla_pkg::OP_READ, 8'h00, 10'd2, 1'b1, cla_pkg::ST_DATA, 5, 8'h20);
        dir_rows[8]  = mk_row(cla_pkg::OP_READ, 8'h00, 10'd3, 1'b1, cla_pkg::ST_DATA, 5, 8'h7F);
        dir_rows[9]  = mk_row(cla_pkg::OP_READ, 8'h00, 10'd4, 1'b0, cla_pkg::ST_WAIT, 0, 8'h00);
        // one trailing backslash and a space: newline continues the line
        dir_rows[10] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_BS, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[11] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_SP, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[12] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_NL, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        // even backslash run: line completes
        dir_rows[13] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_BS, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[14] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_BS, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[15] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_NL, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        // a read keeps the finished line; the next push starts a new one
        dir_rows[16] = mk_row(cla_pkg::OP_READ, 8'hFF, 10'd6, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[17] = mk_row(cla_pkg::OP_PUSH, 8'h62, 10'h3FF, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[18] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_NL, 10'h3FF, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[19] = mk_row(cla_pkg::OP_PUSH, cla_pkg::CH_NL, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[20] = mk_row(cla_pkg::OP_EOF, 8'hFF, 10'h3FF, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[21] = mk_row(OP_UNUSED, 8'hFF, 10'h3FF, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        // end of input completes a non-empty line, then reports end
        dir_rows[22] = mk_row(cla_pkg::OP_PUSH, 8'h63, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[23] = mk_row(cla_pkg::OP_EOF, 8'h00, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);
        dir_rows[24] = mk_row(cla_pkg::OP_EOF, 8'h00, 10'd0, 1'b0,
                              cla_pkg::ST_WAIT, 0, 8'h00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].op, dir_rows[i].byte_value, dir_rows[i].read_index,
                     dir_rows[i].typed, dir_rows[i].want);

        // high bytes kept as they are
        write_high_bytes_cfg(1'b0);
        send_random_traffic(250);

        // back to high bytes as spaces; overflow and long trim
        write_high_bytes_cfg(1'b1);
        send_long_line();
        send_random_traffic(250);

        // last phase opens with a stretch without idling on either side
        write_high_bytes_cfg(1'b0);
        no_idle = 1'b1;
        send_random_traffic(100);
        no_idle = 1'b0;
        send_random_traffic(120);

        wait_results_done();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/cla_pkg.sv
rtl/core/cla_front.sv
rtl/core/cla_back.sv
rtl/core/command_line_assembler_top.sv
tb/testbench.sv
